// File: src/pal_pkg.sv
// Shared types and codes for the positional array list.
// Holds the opcode and status codes and the scan-unit control structs.
// No dependencies.
package pal_pkg;

    typedef logic [1:0] opcode_t;
    typedef logic [1:0] status_t;

    // Operation codes carried in each input beat.
    localparam opcode_t OP_INSERT = 2'd0;
    localparam opcode_t OP_DELETE = 2'd1;
    localparam opcode_t OP_LOCATE = 2'd2;

    // Status codes returned in each output beat.
    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_BADPOS   = 2'd1;
    localparam status_t ST_FULL     = 2'd2;
    localparam status_t ST_NOTFOUND = 2'd3;

    // Commands from the sequencer to the address scan unit.
    typedef struct packed {
        logic start;
        logic up;
        logic stop;
    } scan_ctl_t;

    // Status from the scan unit back to the sequencer.
    typedef struct packed {
        logic rd_en;
        logic pend;
        logic pend_first;
        logic busy;
    } scan_stat_t;

endpackage

// File: src/pal_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Width and depth are parameters. No dependencies.
module pal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: src/pal_scan.sv
// Address scan unit: walks the RAM read address from a first to a last
// address, one step a cycle, and tracks the read whose data is due.
// Depends on pal_pkg.
module pal_scan #(
    parameter int AW = 7
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pal_pkg::scan_ctl_t  ctl,
    input  logic [AW-1:0]       first_addr,
    input  logic [AW-1:0]       last_addr,
    output pal_pkg::scan_stat_t stat,
    output logic [AW-1:0]       rd_addr,
    output logic [AW-1:0]       pend_addr
);

    import pal_pkg::*;

    logic          more_reg, more_next;
    logic          pend_reg, pend_next;
    logic          first_reg, first_next;
    logic          pend_first_reg, pend_first_next;
    logic          up_reg, up_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] last_reg, last_next;
    logic [AW-1:0] pend_addr_reg, pend_addr_next;

    // Step the cursor; a read issued now has its data in the next cycle.
    always_comb
    begin
        more_next       = more_reg;
        pend_next       = more_reg;
        first_next      = first_reg & ~more_reg;
        pend_first_next = more_reg & first_reg;
        up_next         = up_reg;
        idx_next        = idx_reg;
        last_next       = last_reg;
        pend_addr_next  = idx_reg;
        if (more_reg)
        begin
            if (idx_reg == last_reg)
            begin
                more_next = 1'b0;
            end
            else if (up_reg)
            begin
                idx_next = idx_reg + AW'(1);
            end
            else
            begin
                idx_next = idx_reg - AW'(1);
            end
        end
        if (ctl.start)
        begin
            more_next       = 1'b1;
            pend_next       = 1'b0;
            first_next      = 1'b1;
            pend_first_next = 1'b0;
            up_next         = ctl.up;
            idx_next        = first_addr;
            last_next       = last_addr;
        end
        else if (ctl.stop)
        begin
            more_next = 1'b0;
            pend_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            more_reg       <= 1'b0;
            pend_reg       <= 1'b0;
            first_reg      <= 1'b0;
            pend_first_reg <= 1'b0;
        end
        else
        begin
            more_reg       <= more_next;
            pend_reg       <= pend_next;
            first_reg      <= first_next;
            pend_first_reg <= pend_first_next;
        end
    end

    // Address registers.
    always_ff @(posedge clk)
    begin
        up_reg        <= up_next;
        idx_reg       <= idx_next;
        last_reg      <= last_next;
        pend_addr_reg <= pend_addr_next;
    end

    assign stat.rd_en      = more_reg;
    assign stat.pend       = pend_reg;
    assign stat.pend_first = pend_first_reg;
    assign stat.busy       = more_reg | pend_reg;
    assign rd_addr         = idx_reg;
    assign pend_addr       = pend_addr_reg;

endmodule

// File: src/positional_array_list.sv
// Top level of the positional array list: sequencer, count and output register.
// Depends on pal_pkg, pal_ram and pal_scan.
//
// Usage:
// Input channel: in_valid/in_stall with opcode, position and item_value.
// Output channel: out_valid/out_stall with status, removed_value,
// found_position and entry_count. Every accepted beat gives one output beat.
// Insert places a value at a 1-based position (1 to count+1), delete takes
// out the entry at a position (1 to count), and locate returns the first
// position holding a value. Out-of-range positions and opcode 3 answer bad
// position; insert into a full list answers full.
// One operation is in flight at a time; in_stall is high until it ends.
// The entries sit in one single-port-read RAM, so every shift or search moves
// one entry per cycle. Insert shifts the entries from the position up, unless
// it appends at count + 1; delete shifts the entries above the position down;
// locate scans from position 1 and stops at the first match. The next beat
// can be accepted in the same cycle that out_valid rises.
// A finished result waits in the output register while out_stall is high; the
// next input beat is accepted meanwhile, and its result waits for the register.
// Reset empties the list and clears both channels; RAM contents are not
// cleared and are read only after they were written.
module positional_array_list #(
    parameter int CAPACITY = 128
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  pal_pkg::opcode_t       opcode,
    input  logic [7:0]             position,
    input  logic signed [31:0]     item_value,
    output logic                   out_valid,
    input  logic                   out_stall,
    output pal_pkg::status_t       status,
    output logic signed [31:0]     removed_value,
    output logic [7:0]             found_position,
    output logic [7:0]             entry_count
);

    import pal_pkg::*;

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = ((CW > 8) ? CW : 8) + 1;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_INS     = 3'd1;
    localparam logic [2:0] S_INS_PUT = 3'd2;
    localparam logic [2:0] S_DEL     = 3'd3;
    localparam logic [2:0] S_LOC     = 3'd4;
    localparam logic [2:0] S_DONE    = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [31:0]   val_reg, val_next;
    logic [AW-1:0] p0_reg, p0_next;
    status_t       res_status_reg, res_status_next;
    logic [31:0]   res_removed_reg, res_removed_next;
    logic [7:0]    res_found_reg, res_found_next;

    logic          out_valid_reg;
    status_t       out_status_reg;
    logic [31:0]   out_removed_reg;
    logic [7:0]    out_found_reg;
    logic [7:0]    out_count_reg;

    scan_ctl_t     scan_ctl;
    scan_stat_t    scan_stat;
    logic [AW-1:0] first_addr, last_addr, rd_addr, pend_addr;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic [31:0]   rd_data;

    logic [CMPW-1:0] pos_ext, cnt_ext, p0_wide;
    logic            ins_ok, del_ok, out_free, in_acc;

    pal_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (scan_stat.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pal_scan #(
        .AW (AW)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (scan_ctl),
        .first_addr (first_addr),
        .last_addr  (last_addr),
        .stat       (scan_stat),
        .rd_addr    (rd_addr),
        .pend_addr  (pend_addr)
    );

    // Position range checks against the live count.
    assign pos_ext  = CMPW'(position);
    assign cnt_ext  = CMPW'(count_reg);
    assign p0_wide  = pos_ext - CMPW'(1);
    assign ins_ok   = (position != 8'd0) && (pos_ext <= cnt_ext + CMPW'(1));
    assign del_ok   = (position != 8'd0) && (pos_ext <= cnt_ext);
    assign out_free = !out_valid_reg || !out_stall;
    assign in_acc   = in_valid && !in_stall;

    // Sequencer: decode the beat, drive the scan unit and the RAM write port.
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        val_next         = val_reg;
        p0_next          = p0_reg;
        res_status_next  = res_status_reg;
        res_removed_next = res_removed_reg;
        res_found_next   = res_found_reg;
        scan_ctl         = '0;
        first_addr       = '0;
        last_addr        = '0;
        wr_en            = 1'b0;
        wr_addr          = pend_addr;
        wr_data          = rd_data;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    val_next         = item_value;
                    p0_next          = AW'(p0_wide);
                    res_status_next  = ST_OK;
                    res_removed_next = '0;
                    res_found_next   = '0;
                    case (opcode)
                        OP_INSERT:
                        begin
                            if (!ins_ok)
                            begin
                                res_status_next = ST_BADPOS;
                                state_next      = S_DONE;
                            end
                            else if (count_reg == CW'(CAPACITY))
                            begin
                                res_status_next = ST_FULL;
                                state_next      = S_DONE;
                            end
                            else if (cnt_ext == p0_wide)
                            begin
                                state_next = S_INS_PUT;
                            end
                            else
                            begin
                                scan_ctl.start = 1'b1;
                                scan_ctl.up    = 1'b0;
                                first_addr     = AW'(count_reg - CW'(1));
                                last_addr      = AW'(p0_wide);
                                state_next     = S_INS;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (!del_ok)
                            begin
                                res_status_next = ST_BADPOS;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                scan_ctl.start = 1'b1;
                                scan_ctl.up    = 1'b1;
                                first_addr     = AW'(p0_wide);
                                last_addr      = AW'(count_reg - CW'(1));
                                state_next     = S_DEL;
                            end
                        end
                        OP_LOCATE:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = ST_NOTFOUND;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                scan_ctl.start = 1'b1;
                                scan_ctl.up    = 1'b1;
                                first_addr     = '0;
                                last_addr      = AW'(count_reg - CW'(1));
                                state_next     = S_LOC;
                            end
                        end
                        default:
                        begin
                            res_status_next = ST_BADPOS;
                            state_next      = S_DONE;
                        end
                    endcase
                end
            end
            S_INS:
            begin
                // Move each entry one place up, from the top down.
                if (scan_stat.pend)
                begin
                    wr_en   = 1'b1;
                    wr_addr = pend_addr + AW'(1);
                end
                if (!scan_stat.busy)
                begin
                    state_next = S_INS_PUT;
                end
            end
            S_INS_PUT:
            begin
                wr_en      = 1'b1;
                wr_addr    = p0_reg;
                wr_data    = val_reg;
                count_next = count_reg + CW'(1);
                state_next = S_DONE;
            end
            S_DEL:
            begin
                // The first read is the removed entry; the rest move down.
                if (scan_stat.pend)
                begin
                    if (scan_stat.pend_first)
                    begin
                        res_removed_next = rd_data;
                    end
                    else
                    begin
                        wr_en   = 1'b1;
                        wr_addr = pend_addr - AW'(1);
                    end
                end
                if (!scan_stat.busy)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_DONE;
                end
            end
            S_LOC:
            begin
                if (scan_stat.pend && (rd_data == val_reg))
                begin
                    res_found_next = 8'({1'b0, pend_addr} + (AW + 1)'(1));
                    scan_ctl.stop  = 1'b1;
                    state_next     = S_DONE;
                end
                else if (!scan_stat.busy)
                begin
                    res_status_next = ST_NOTFOUND;
                    state_next      = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer state and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Operand and result holding registers.
    always_ff @(posedge clk)
    begin
        val_reg         <= val_next;
        p0_reg          <= p0_next;
        res_status_reg  <= res_status_next;
        res_removed_reg <= res_removed_next;
        res_found_reg   <= res_found_next;
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == S_DONE) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_DONE) && out_free)
        begin
            out_status_reg  <= res_status_reg;
            out_removed_reg <= res_removed_reg;
            out_found_reg   <= res_found_reg;
            out_count_reg   <= 8'(count_reg);
        end
    end

    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign removed_value  = out_removed_reg;
    assign found_position = out_found_reg;
    assign entry_count    = out_count_reg;

    // The count never grows past the table.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");

    // A shift never writes the entry that is being read in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && scan_stat.rd_en) |-> (wr_addr != rd_addr))
    else $error("RAM write and read collide");

    // A new output beat only follows a finished operation.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
    else $error("output beat without a finished operation");

    // An accepted beat always starts an operation.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (state_reg != S_IDLE))
    else $error("accepted beat left the sequencer idle");

    // The scan unit runs only while a shift or search state owns it.
    assert property (@(posedge clk) disable iff (!rst_n)
        scan_stat.busy |-> ((state_reg == S_INS) || (state_reg == S_DEL)
                            || (state_reg == S_LOC)))
    else $error("scan unit busy outside a scan state");

endmodule
